// ===== rtl/mspt_pkg.sv =====
// types, codes and defaults shared by the multi-slot periodic timer
package mspt_pkg;

   localparam int SLOTS_DEFAULT = 16;

   localparam logic [1:0] CMD_TICK     = 2'd0;
   localparam logic [1:0] CMD_REGISTER = 2'd1;
   localparam logic [1:0] CMD_CANCEL   = 2'd2;

   localparam logic [1:0] KIND_ACCEPT = 2'd0;
   localparam logic [1:0] KIND_REJECT = 2'd1;
   localparam logic [1:0] KIND_FIRE   = 2'd2;
   localparam logic [1:0] KIND_TICK   = 2'd3;

   typedef struct packed {
      logic [1:0]  command;
      logic [3:0]  slot;
      logic [31:0] period;
      logic        one_shot;
      logic [31:0] user_tag;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  fired_slot;
      logic [31:0] fired_tag;
      logic        fired_one_shot;
      logic [63:0] time_now;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic        once;
      logic [31:0] period;
      logic [31:0] age;
      logic [31:0] tag;
   } entry_type;

endpackage

// ===== rtl/mspt_ram.sv =====
// generic simple dual-port ram with registered read
module mspt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/multi_slot_periodic_timer.sv =====
// bank of periodic and one-shot timer slots driven by command items
//
// req channel (valid/ready) carries one command item: tick, register or cancel.
// rsp channel (valid/ready) returns result items from a single output register.
// register and cancel give one result, presented the cycle after acceptance.
// a tick increments the 64-bit time count, then scans the slots one per cycle
// through the slot ram (registered read, age written back as the scan
// moves on), giving a fire item for each due slot in slot order, then a
// tick-done item with last set. the single ram read port visits one slot per
// cycle while no fire item waits on a stalled receiver.
// one command is in progress at a time; req_ready is high only between
// commands while the output register is free or being emptied.
// when the receiver stalls with a fire item pending, the scan holds on the
// current slot until the output register frees.
// reset clears the armed flags, the time count and the output valid flag; slot
// settings in the ram are only read for armed slots, so need no clearing.
module multi_slot_periodic_timer
   import mspt_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_item
);

   localparam int IW = SLOTS > 1 ? $clog2(SLOTS) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [63:0]      now_ff, now_in;
   logic [SLOTS-1:0] armed_ff, armed_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             rsp_load;
   logic             rsp_free;
   logic             wr_en;
   logic [IW-1:0]    wr_addr;
   entry_type        wr_data;
   logic [IW-1:0]    rd_addr;
   logic [$bits(entry_type)-1:0] rd_raw;
   entry_type        rd_entry;
   logic [31:0]      age_inc;
   logic             due;
   logic             advance;
   logic [IW-1:0]    slot_addr;
   logic             slot_ok;

   mspt_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(SLOTS)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_raw)
   );

   assign rd_entry  = entry_type'(rd_raw);
   assign age_inc   = rd_entry.age + 32'd1;
   assign due       = armed_ff[idx_ff] && (age_inc >= rd_entry.period);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = !due || rsp_free;
   assign slot_addr = IW'(req_item.slot);
   assign slot_ok   = 32'(req_item.slot) < SLOTS;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      now_in    = now_ff;
      armed_in  = armed_ff;
      rsp_load  = 1'b0;
      rsp_in    = rsp_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = rd_entry;
      rd_addr   = idx_ff;
      req_ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = rsp_free;
            if (req_valid && rsp_free) begin
               rsp_in.kind           = KIND_REJECT;
               rsp_in.fired_slot     = req_item.slot;
               rsp_in.fired_tag      = 32'd0;
               rsp_in.fired_one_shot = 1'b0;
               rsp_in.time_now       = now_ff;
               rsp_in.last           = 1'b1;
               unique case (req_item.command)
                  CMD_TICK: begin
                     now_in   = now_ff + 64'd1;
                     idx_in   = '0;
                     state_in = ST_SCAN;
                  end
                  CMD_REGISTER: begin
                     rsp_load = 1'b1;
                     if (slot_ok && req_item.period != 32'd0) begin
                        armed_in[slot_addr] = 1'b1;
                        wr_en          = 1'b1;
                        wr_addr        = slot_addr;
                        wr_data.once   = req_item.one_shot;
                        wr_data.period = req_item.period;
                        wr_data.age    = 32'd0;
                        wr_data.tag    = req_item.user_tag;
                        rsp_in.kind    = KIND_ACCEPT;
                     end
                  end
                  CMD_CANCEL: begin
                     rsp_load = 1'b1;
                     if (slot_ok) begin
                        armed_in[slot_addr] = 1'b0;
                        rsp_in.kind = KIND_ACCEPT;
                     end
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (advance) begin
               if (armed_ff[idx_ff]) begin
                  wr_en       = 1'b1;
                  wr_data.age = due ? 32'd0 : age_inc;
               end
               if (due) begin
                  rsp_load              = 1'b1;
                  rsp_in.kind           = KIND_FIRE;
                  rsp_in.fired_slot     = 4'(idx_ff);
                  rsp_in.fired_tag      = rd_entry.tag;
                  rsp_in.fired_one_shot = rd_entry.once;
                  rsp_in.time_now       = now_ff;
                  rsp_in.last           = 1'b0;
                  if (rd_entry.once) begin
                     armed_in[idx_ff] = 1'b0;
                  end
               end
               if (idx_ff == LAST_IDX) begin
                  idx_in   = '0;
                  rd_addr  = '0;
                  state_in = ST_DONE;
               end else begin
                  idx_in  = IW'(idx_ff + 1'b1);
                  rd_addr = IW'(idx_ff + 1'b1);
               end
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_load              = 1'b1;
               rsp_in.kind           = KIND_TICK;
               rsp_in.fired_slot     = 4'd0;
               rsp_in.fired_tag      = 32'd0;
               rsp_in.fired_one_shot = 1'b0;
               rsp_in.time_now       = now_ff;
               rsp_in.last           = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            idx_in   = '0;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         now_ff       <= 64'd0;
         armed_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         now_ff       <= now_in;
         armed_ff     <= armed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_tick_increments: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_item.command == CMD_TICK)
      |=> (now_ff == $past(now_ff) + 64'd1))
      else $error("time count did not advance on tick");

   a_time_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && req_ready && req_item.command == CMD_TICK) |=> $stable(now_ff))
      else $error("time count moved without a tick");

   a_scan_never_arms: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |=> ((armed_ff & ~$past(armed_ff)) == '0))
      else $error("slot armed during tick scan");

   a_fire_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && state_ff == ST_SCAN) |=> (!rsp_ff.last && rsp_ff.kind == KIND_FIRE))
      else $error("fire item loaded with wrong kind or last flag");

endmodule
